[hw/rtl/pcm_pkg.sv]
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types, codes and constants of the PWM capture measurement block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_pkg;

  localparam int TIME_W    = 16;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int FREQ_W    = 20;
  localparam int DUTY_W    = 7;
  localparam int LIMIT_W   = 26;
  localparam int PERIOD_W  = TIME_W + 1;
  localparam int DIV_N_W   = 23;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam int TICK_HZ          = 1000000;
  localparam int PERCENT          = 100;
  localparam int TICKS_PER_MS     = 1000;
  localparam int TIMEOUT_RESET_MS = 1000;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(TIMEOUT_RESET_MS * TICKS_PER_MS);

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_MEASURED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREQ_GO,
    ST_FREQ_RUN,
    ST_DUTY_GO,
    ST_DUTY_RUN,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_duty;
    logic cap_freq;
    logic cap_duty;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic res_now;
    logic res_meas;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/pcm_div.sv]
// ----------------------------------------------------------------------------
// pcm_div
// Restoring divider, one quotient bit per cycle, done pulses after the last.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pcm_pkg::DIV_N_W-1:0]   dividend,
  input  wire logic [pcm_pkg::PERIOD_W-1:0]  divisor,
  output logic                               done,
  output logic [pcm_pkg::DIV_N_W-1:0]        quotient
);

  localparam logic [pcm_pkg::DIV_CNT_W-1:0] DIV_LAST =
    pcm_pkg::DIV_CNT_W'(pcm_pkg::DIV_N_W - 1);

  logic                            busy;
  logic [pcm_pkg::DIV_CNT_W-1:0]   cnt;
  logic [pcm_pkg::DIV_N_W-1:0]     q;
  logic [pcm_pkg::PERIOD_W-1:0]    rem;
  logic [pcm_pkg::PERIOD_W-1:0]    div_r;
  logic [pcm_pkg::PERIOD_W:0]      trial;
  logic [pcm_pkg::PERIOD_W:0]      diff;
  logic                            fit;

  assign trial    = {rem, q[pcm_pkg::DIV_N_W-1]};
  assign diff     = trial - {1'b0, div_r};
  assign fit      = !diff[pcm_pkg::PERIOD_W];
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dividend;
      rem   <= '0;
      div_r <= divisor;
    end else if (busy) begin
      q   <= {q[pcm_pkg::DIV_N_W-2:0], fit};
      rem <= fit ? diff[pcm_pkg::PERIOD_W-1:0] : trial[pcm_pkg::PERIOD_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pcm_datapath.sv]
// ----------------------------------------------------------------------------
// pcm_datapath
// Capture state, timeout counter, divider operands and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pcm_pkg::ctrl_cmd_t            cmd,
  output pcm_pkg::dp_status_t                status,
  input  wire logic [pcm_pkg::KIND_W-1:0]    kind,
  input  wire logic [pcm_pkg::TIME_W-1:0]    capture_time,
  input  wire logic                          edge_rising,
  input  wire logic                          pin_level,
  input  wire logic                          cfg_we,
  input  wire logic [pcm_pkg::TIME_W-1:0]    cfg_data,
  output logic [pcm_pkg::STATUS_W-1:0]       out_status,
  output logic [pcm_pkg::FREQ_W-1:0]         out_freq,
  output logic [pcm_pkg::DUTY_W-1:0]         out_duty
);

  localparam logic [1:0] PHASE_RISE1 = 2'd0;
  localparam logic [1:0] PHASE_FALL  = 2'd1;
  localparam logic [1:0] PHASE_RISE2 = 2'd2;

  logic [pcm_pkg::LIMIT_W-1:0]  limit;
  logic                         armed;
  logic [1:0]                   phase;
  logic [pcm_pkg::TIME_W-1:0]   first_rise;
  logic [pcm_pkg::TIME_W-1:0]   fall_time;
  logic [pcm_pkg::LIMIT_W-1:0]  elapsed;
  logic [pcm_pkg::PERIOD_W-1:0] period_r;
  logic [pcm_pkg::TIME_W-1:0]   high_r;
  logic [pcm_pkg::STATUS_W-1:0] res_status;
  logic [pcm_pkg::FREQ_W-1:0]   res_freq;
  logic [pcm_pkg::DUTY_W-1:0]   res_duty;

  logic [pcm_pkg::TIME_W-1:0]   high_w;
  logic [pcm_pkg::TIME_W-1:0]   low_w;
  logic [pcm_pkg::PERIOD_W-1:0] period_w;
  logic [pcm_pkg::LIMIT_W-1:0]  elapsed_inc;
  logic                         tick_expired;
  logic                         rise2_hit;
  logic [pcm_pkg::STATUS_W-1:0] now_status;
  logic [pcm_pkg::DUTY_W-1:0]   now_duty;
  logic [pcm_pkg::DIV_N_W-1:0]  duty_num;
  logic [pcm_pkg::DIV_N_W-1:0]  div_dividend;
  logic [pcm_pkg::DIV_N_W-1:0]  quotient;
  logic                         div_done;

  assign high_w       = fall_time - first_rise;
  assign low_w        = capture_time - fall_time;
  assign period_w     = {1'b0, high_w} + {1'b0, low_w};
  assign elapsed_inc  = elapsed + 1'b1;
  assign tick_expired = elapsed_inc >= limit;
  assign rise2_hit    = armed && (phase == PHASE_RISE2) && edge_rising;

  always_comb begin
    status.res_now  = 1'b0;
    status.res_meas = 1'b0;
    status.div_done = div_done;
    now_status      = pcm_pkg::STATUS_TIMEOUT;
    now_duty        = pin_level ? pcm_pkg::DUTY_W'(pcm_pkg::PERCENT) : '0;
    case (kind)
      pcm_pkg::KIND_START: begin
        status.res_now = (limit == '0);
      end
      pcm_pkg::KIND_EDGE: begin
        if (rise2_hit) begin
          if (period_w == '0) begin
            status.res_now = 1'b1;
            now_status     = pcm_pkg::STATUS_ZERO;
            now_duty       = '0;
          end else begin
            status.res_meas = 1'b1;
          end
        end
      end
      pcm_pkg::KIND_TICK: begin
        status.res_now = armed && tick_expired;
      end
      default: begin
        status.res_now = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit   <= pcm_pkg::LIMIT_RESET;
      armed   <= 1'b0;
      phase   <= PHASE_RISE1;
      elapsed <= '0;
    end else begin
      if (cfg_we) begin
        limit <= pcm_pkg::LIMIT_W'(cfg_data) * pcm_pkg::LIMIT_W'(pcm_pkg::TICKS_PER_MS);
      end
      if (cmd.accept) begin
        case (kind)
          pcm_pkg::KIND_START: begin
            armed   <= (limit != '0);
            phase   <= PHASE_RISE1;
            elapsed <= '0;
          end
          pcm_pkg::KIND_EDGE: begin
            if (armed) begin
              case (phase)
                PHASE_RISE1: if (edge_rising) phase <= PHASE_FALL;
                PHASE_FALL:  if (!edge_rising) phase <= PHASE_RISE2;
                default: begin
                  if (edge_rising) begin
                    armed <= 1'b0;
                    phase <= PHASE_RISE1;
                  end
                end
              endcase
            end
          end
          pcm_pkg::KIND_TICK: begin
            if (armed) begin
              elapsed <= elapsed_inc;
              if (tick_expired) begin
                armed <= 1'b0;
                phase <= PHASE_RISE1;
              end
            end
          end
          default: begin
            armed <= armed;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && armed && (kind == pcm_pkg::KIND_EDGE)) begin
      if ((phase == PHASE_RISE1) && edge_rising) begin
        first_rise <= capture_time;
      end
      if ((phase == PHASE_FALL) && !edge_rising) begin
        fall_time <= capture_time;
      end
    end
    if (cmd.accept && status.res_now) begin
      res_status <= now_status;
      res_freq   <= '0;
      res_duty   <= now_duty;
    end
    if (cmd.accept && status.res_meas) begin
      period_r   <= period_w;
      high_r     <= high_w;
      res_status <= pcm_pkg::STATUS_MEASURED;
    end
    if (cmd.cap_freq) begin
      res_freq <= quotient[pcm_pkg::FREQ_W-1:0];
    end
    if (cmd.cap_duty) begin
      res_duty <= quotient[pcm_pkg::DUTY_W-1:0];
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_freq   <= res_freq;
      out_duty   <= res_duty;
    end
  end

  assign duty_num     = pcm_pkg::DIV_N_W'(high_r) * pcm_pkg::DIV_N_W'(pcm_pkg::PERCENT);
  assign div_dividend = cmd.div_duty ? duty_num : pcm_pkg::DIV_N_W'(pcm_pkg::TICK_HZ);

  pcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (period_r),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

`default_nettype wire

[hw/rtl/pcm_ctrl.sv]
// ----------------------------------------------------------------------------
// pcm_ctrl
// Sequencer: input handshake, two divider runs per measurement, output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire pcm_pkg::dp_status_t  status,
  output pcm_pkg::ctrl_cmd_t        cmd
);

  pcm_pkg::state_t state;
  pcm_pkg::state_t state_next;
  logic            slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcm_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcm_pkg::ST_IDLE: begin
        if (in_valid && status.res_now) begin
          state_next = pcm_pkg::ST_LOAD;
        end else if (in_valid && status.res_meas) begin
          state_next = pcm_pkg::ST_FREQ_GO;
        end
      end
      pcm_pkg::ST_FREQ_GO:  state_next = pcm_pkg::ST_FREQ_RUN;
      pcm_pkg::ST_FREQ_RUN: if (status.div_done) state_next = pcm_pkg::ST_DUTY_GO;
      pcm_pkg::ST_DUTY_GO:  state_next = pcm_pkg::ST_DUTY_RUN;
      pcm_pkg::ST_DUTY_RUN: if (status.div_done) state_next = pcm_pkg::ST_LOAD;
      pcm_pkg::ST_LOAD:     if (slot_free) state_next = pcm_pkg::ST_IDLE;
      default:              state_next = pcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == pcm_pkg::ST_IDLE);
    cmd.accept    = (state == pcm_pkg::ST_IDLE) && in_valid;
    cmd.div_start = (state == pcm_pkg::ST_FREQ_GO) || (state == pcm_pkg::ST_DUTY_GO);
    cmd.div_duty  = (state == pcm_pkg::ST_DUTY_GO);
    cmd.cap_freq  = (state == pcm_pkg::ST_FREQ_RUN) && status.div_done;
    cmd.cap_duty  = (state == pcm_pkg::ST_DUTY_RUN) && status.div_done;
    cmd.load_out  = (state == pcm_pkg::ST_LOAD) && slot_free;
  end

endmodule

`default_nettype wire

[hw/rtl/pwm_capture_measure.sv]
// ----------------------------------------------------------------------------
// pwm_capture_measure
// PWM frequency and duty measurement from input-capture timestamps.
// Start, edge and tick items without a result are taken one per cycle.
// A timeout or zero-period result goes through the load state into the output
// register once the output slot is free, and the input reopens in the same cycle
// that it turns valid. A full measurement does so after two 23-step runs of the
// shared restoring divider (frequency, then duty). A stalled output delays both.
// Synchronous reset clears the sequencer and disarms; timeout returns to 1000 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_capture_measure (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // capture_time[15:0], edge_rising, pin_level
  input  wire logic [1:0]  s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // freq_hz[19:0], duty_percent[6:0]
  output logic [1:0]       m_axis_tuser,  // status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data       // timeout_ms
);

  pcm_pkg::ctrl_cmd_t            cmd;
  pcm_pkg::dp_status_t           status;
  logic [pcm_pkg::STATUS_W-1:0]  out_status;
  logic [pcm_pkg::FREQ_W-1:0]    out_freq;
  logic [pcm_pkg::DUTY_W-1:0]    out_duty;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {5'd0, out_duty, out_freq};
  assign m_axis_tuser = out_status;

  pcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pcm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (s_axis_tuser),
    .capture_time (s_axis_tdata[15:0]),
    .edge_rising  (s_axis_tdata[16]),
    .pin_level    (s_axis_tdata[17]),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .out_status   (out_status),
    .out_freq     (out_freq),
    .out_duty     (out_duty)
  );

endmodule

`default_nettype wire

[tb/pwm_capture_measure_test.sv]
// ----------------------------------------------------------------------------
// pwm_capture_measure_test
// Drives start, edge and tick items into the PWM measurement block over the
// input stream and checks every result against a cycle-free predictor of the
// capture sequence, the divisions and the timeout, under several timeout
// settings and patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module pwm_capture_measure_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pcm_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 35;

  typedef struct packed {
    logic [pcm_pkg::STATUS_W-1:0] status;
    logic [pcm_pkg::FREQ_W-1:0]   freq_hz;
    logic [pcm_pkg::DUTY_W-1:0]   duty_percent;
  } meas_t;

  typedef enum logic [1:0] {
    WAIT_RISE,
    WAIT_FALL,
    WAIT_RISE2
  } capture_phase_t;

  class pwm_meas_book;
    logic [pcm_pkg::TIME_W-1:0]  timeout_ms = pcm_pkg::TIME_W'(pcm_pkg::TIMEOUT_RESET_MS);
    capture_phase_t              phase = WAIT_RISE;
    bit                          armed = 1'b0;
    logic [pcm_pkg::TIME_W-1:0]  first_rise = '0;
    logic [pcm_pkg::TIME_W-1:0]  fall_time = '0;
    logic [pcm_pkg::LIMIT_W-1:0] elapsed_us = '0;
    meas_t                       pending_q[$];
    int                          mismatches = 0;
    int                          n_items = 0;
    int                          n_meas = 0;
    int                          n_timeout = 0;
    int                          n_zero = 0;

    function void set_timeout(logic [pcm_pkg::TIME_W-1:0] ms);
      timeout_ms = ms;
    endfunction

    function void push_result(logic [pcm_pkg::STATUS_W-1:0] st, int unsigned f,
                              int unsigned d);
      meas_t m;
      m.status       = st;
      m.freq_hz      = pcm_pkg::FREQ_W'(f);
      m.duty_percent = pcm_pkg::DUTY_W'(d);
      pending_q.push_back(m);
      armed = 1'b0;
      phase = WAIT_RISE;
    endfunction

    // returns 1 when the item changes the measurement or yields a result
    function bit note_item(logic [pcm_pkg::KIND_W-1:0] kind, logic [pcm_pkg::TIME_W-1:0] t,
                           logic rise, logic lvl);
      int unsigned limit;
      int unsigned high;
      int unsigned low;
      int unsigned period;
      limit = int'(timeout_ms) * pcm_pkg::TICKS_PER_MS;
      n_items++;
      if (kind == pcm_pkg::KIND_START) begin
        armed      = 1'b1;
        phase      = WAIT_RISE;
        elapsed_us = '0;
        if (limit == 0) push_result(pcm_pkg::STATUS_TIMEOUT, 0, lvl ? pcm_pkg::PERCENT : 0);
        return 1'b1;
      end
      if (!armed) return 1'b0;
      if (kind == pcm_pkg::KIND_EDGE) begin
        case (phase)
          WAIT_RISE: begin
            if (!rise) return 1'b0;
            first_rise = t;
            phase      = WAIT_FALL;
          end
          WAIT_FALL: begin
            if (rise) return 1'b0;
            fall_time = t;
            phase     = WAIT_RISE2;
          end
          default: begin
            if (!rise) return 1'b0;
            high   = int'(pcm_pkg::TIME_W'(fall_time - first_rise));
            low    = int'(pcm_pkg::TIME_W'(t - fall_time));
            period = high + low;
            if (period == 0) push_result(pcm_pkg::STATUS_ZERO, 0, 0);
            else push_result(pcm_pkg::STATUS_MEASURED, pcm_pkg::TICK_HZ / period,
                             high * pcm_pkg::PERCENT / period);
          end
        endcase
        return 1'b1;
      end
      if (kind == pcm_pkg::KIND_TICK) begin
        elapsed_us = elapsed_us + 1'b1;
        if (elapsed_us >= limit)
          push_result(pcm_pkg::STATUS_TIMEOUT, 0, lvl ? pcm_pkg::PERCENT : 0);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_meas(meas_t got);
      meas_t want;
      if (pending_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status %0d freq %0d duty %0d",
                   got.status, got.freq_hz, got.duty_percent);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      case (want.status)
        pcm_pkg::STATUS_MEASURED: n_meas++;
        pcm_pkg::STATUS_TIMEOUT:  n_timeout++;
        default:                  n_zero++;
      endcase
      if (got.status !== want.status || got.freq_hz !== want.freq_hz ||
          got.duty_percent !== want.duty_percent) begin
        if (mismatches < 10)
          $display({"mismatch: expected status %0d freq %0d duty %0d, ",
                    "got status %0d freq %0d duty %0d"},
                   want.status, want.freq_hz, want.duty_percent,
                   got.status, got.freq_hz, got.duty_percent);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // capture_time[15:0], edge_rising, pin_level
  logic [1:0]  s_axis_tuser = '0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // freq_hz[19:0], duty_percent[6:0]
  logic [1:0]  m_axis_tuser;       // status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;      // timeout_ms

  pwm_meas_book book = new;
  int send_pct = 0;
  int recv_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  pwm_capture_measure dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      book.check_meas({m_axis_tuser, m_axis_tdata[19:0], m_axis_tdata[26:20]});
  end

  task automatic send_item(input logic [pcm_pkg::KIND_W-1:0] kind,
                           input logic [pcm_pkg::TIME_W-1:0] t,
                           input logic rise, input logic lvl);
    int gap;
    gap = 0;
    while (send_pct > 0 && $urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, lvl, rise, t};
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    void'(book.note_item(kind, t, rise, lvl));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (book.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [pcm_pkg::TIME_W-1:0] ms);
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    book.set_timeout(ms);
  endtask

  function automatic logic [pcm_pkg::TIME_W-1:0] pick_span();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(1, 20));
      4: return 16'($urandom_range(100, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic some_ticks();
    repeat ($urandom_range(2))
      send_item(pcm_pkg::KIND_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic random_sequence();
    logic [pcm_pkg::TIME_W-1:0] t0;
    logic [pcm_pkg::TIME_W-1:0] hi;
    logic [pcm_pkg::TIME_W-1:0] lo;
    int r;
    r  = $urandom_range(99);
    t0 = 16'($urandom);
    hi = pick_span();
    lo = pick_span();
    if ($urandom_range(9) == 0) begin
      hi = '0;
      lo = '0;
    end
    if (r < 70) begin
      send_item(pcm_pkg::KIND_START, 16'($urandom), 1'($urandom), 1'($urandom));
      if ($urandom_range(2) == 0)
        send_item(pcm_pkg::KIND_EDGE, 16'($urandom), 1'b0, 1'($urandom));
      some_ticks();
      send_item(pcm_pkg::KIND_EDGE, t0, 1'b1, 1'($urandom));
      if ($urandom_range(2) == 0)
        send_item(pcm_pkg::KIND_EDGE, 16'($urandom), 1'b1, 1'($urandom));
      some_ticks();
      send_item(pcm_pkg::KIND_EDGE, 16'(t0 + hi), 1'b0, 1'($urandom));
      if ($urandom_range(2) == 0)
        send_item(pcm_pkg::KIND_EDGE, 16'($urandom), 1'b0, 1'($urandom));
      some_ticks();
      send_item(pcm_pkg::KIND_EDGE, 16'(t0 + hi + lo), 1'b1, 1'($urandom));
    end else if (r < 85) begin
      // broken sequence, the next start restarts it
      send_item(pcm_pkg::KIND_START, 16'($urandom), 1'($urandom), 1'($urandom));
      send_item(pcm_pkg::KIND_EDGE, t0, 1'b1, 1'($urandom));
      if ($urandom_range(1) == 1)
        send_item(pcm_pkg::KIND_EDGE, 16'(t0 + hi), 1'b0, 1'($urandom));
      some_ticks();
    end else begin
      repeat ($urandom_range(1, 4))
        send_item(pcm_pkg::KIND_W'($urandom_range(3)), 16'($urandom), 1'($urandom),
                  1'($urandom));
    end
  endtask

  task automatic random_phase(input int budget);
    int first;
    first = book.n_items;
    while (book.n_items - first < budget) random_sequence();
  endtask

  initial begin
    logic [pcm_pkg::TIME_W-1:0] last_ms;
    last_ms = 16'($urandom_range(2, 65534));
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // not armed: ignored
    send_item(pcm_pkg::KIND_EDGE, 16'h1234, 1'b1, 1'b1);
    send_item(pcm_pkg::KIND_TICK, 16'h0000, 1'b0, 1'b1);
    send_item(KIND_SPARE, 16'hFFFF, 1'b1, 1'b1);
    // shortest period, all low
    send_item(pcm_pkg::KIND_START, 16'h0000, 1'b0, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'd10, 1'b1, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'd10, 1'b0, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'd11, 1'b1, 1'b1);
    // longest period
    send_item(pcm_pkg::KIND_START, 16'hFFFF, 1'b1, 1'b1);
    send_item(pcm_pkg::KIND_EDGE, 16'h0000, 1'b1, 1'b1);
    send_item(pcm_pkg::KIND_EDGE, 16'hFFFF, 1'b0, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'hFFFE, 1'b1, 1'b1);
    // timer wrap with wrong-polarity edges in every phase
    send_item(pcm_pkg::KIND_START, 16'h5555, 1'b0, 1'b1);
    send_item(pcm_pkg::KIND_EDGE, 16'hAAAA, 1'b0, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'hFFF0, 1'b1, 1'b1);
    send_item(pcm_pkg::KIND_EDGE, 16'h0001, 1'b1, 1'b1);
    send_item(pcm_pkg::KIND_EDGE, 16'h0010, 1'b0, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'h0015, 1'b0, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'h0020, 1'b1, 1'b1);
    // zero period
    send_item(pcm_pkg::KIND_START, 16'h0000, 1'b0, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'd5, 1'b1, 1'b1);
    send_item(pcm_pkg::KIND_EDGE, 16'd5, 1'b0, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'd5, 1'b1, 1'b1);
    // shortest period, all high
    send_item(pcm_pkg::KIND_START, 16'h0000, 1'b0, 1'b1);
    send_item(pcm_pkg::KIND_EDGE, 16'd7, 1'b1, 1'b1);
    send_item(pcm_pkg::KIND_EDGE, 16'd8, 1'b0, 1'b0);
    send_item(pcm_pkg::KIND_EDGE, 16'd8, 1'b1, 1'b1);
    settle();

    // zero timeout fires on the start itself
    write_timeout(16'd0);
    send_item(pcm_pkg::KIND_START, 16'h0000, 1'b0, 1'b1);
    send_item(pcm_pkg::KIND_START, 16'h0000, 1'b0, 1'b0);
    settle();

    write_timeout(16'hFFFF);
    hold_left = 400;
    random_phase(PHASE_ITEMS);
    settle();

    write_timeout(16'd0);
    send_pct = 85;
    random_phase(PHASE_ITEMS);
    settle();

    write_timeout(16'd1);
    send_pct = 0;
    recv_pct = 85;
    send_item(pcm_pkg::KIND_START, 16'($urandom), 1'($urandom), 1'($urandom));
    send_item(pcm_pkg::KIND_EDGE, 16'h0100, 1'b1, 1'b1);
    send_item(pcm_pkg::KIND_EDGE, 16'h0180, 1'b0, 1'b0);
    repeat (pcm_pkg::TICKS_PER_MS)
      send_item(pcm_pkg::KIND_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
    random_phase(PHASE_ITEMS);
    settle();

    write_timeout(last_ms);
    send_pct = 16;
    recv_pct = 16;
    random_phase(PHASE_ITEMS);
    settle();

    $display("%0d items in: %0d measurements, %0d timeouts, %0d zero periods checked",
             book.n_items, book.n_meas, book.n_timeout, book.n_zero);
    $display("timeouts of 1000, 0, 65535, 1 and %0d ms under free, gapped and stalled flow",
             last_ms);
    if (book.mismatches == 0 && book.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", book.mismatches, book.pending_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
